// ===== hdl/bba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// shared types and codes for the block allocation bitmap
// ----------------------------------------------------------------------------
package bba_pkg;

   localparam logic [2:0] ACT_FIND      = 3'd0;
   localparam logic [2:0] ACT_MARK_USED = 3'd1;
   localparam logic [2:0] ACT_MARK_FREE = 3'd2;
   localparam logic [2:0] ACT_LOAD      = 3'd3;
   localparam logic [2:0] ACT_SET_COUNT = 3'd4;

   localparam logic CSR_FILE_ID        = 1'b0;
   localparam logic CSR_FRAGMENT_INDEX = 1'b1;

   localparam logic [7:0] BYTE_FULL = 8'hFF;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MODIFY,
      ST_SCAN,
      ST_RESP
   } state_type;

endpackage

// ===== hdl/bitmap_block_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// usage bitmap with first-free search, mark, byte load, count set and running checksum
// ----------------------------------------------------------------------------
// set count and undefined actions go straight to the result; mark and
// load byte read and write back the byte; find reads one bitmap byte per cycle
// throughput: one beat at a time, next beat taken once the result is staged
// reset: a clearing pass zeroes the bitmap memory, no request beat is taken
// during it; count, checksum and headers reset to zero
module bitmap_block_allocator #(
   parameter int MAP_BYTES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_action,
   input  logic [10:0] req_block,
   input  logic [15:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [10:0] rsp_found_block,
   output logic        rsp_found,
   output logic [15:0] rsp_allocated_out,
   output logic [15:0] rsp_checksum,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int AW = $clog2(MAP_BYTES);
   localparam int CW = $clog2(MAP_BYTES + 1);
   localparam int BW = AW + 3;

   logic [7:0] mem [MAP_BYTES];

   bba_pkg::state_type state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic          rd_vld_ff, rd_vld_in;
   logic [AW-1:0] rd_idx_ff;
   logic [7:0]    rd_data_ff;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [7:0]    mem_wdata;

   logic [2:0]  act_ff, act_in;
   logic [10:0] blk_ff, blk_in;
   logic [15:0] val_ff, val_in;
   logic [15:0] count_ff, count_in;
   logic [15:0] sum_ff, sum_in;
   logic [15:0] hdr_file_id_ff, hdr_frag_ff;
   logic [10:0] res_block_ff, res_block_in;
   logic        res_found_ff, res_found_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [10:0] rsp_block_ff, rsp_block_in;
   logic        rsp_found_ff, rsp_found_in;
   logic [15:0] rsp_count_ff, rsp_count_in;
   logic [15:0] rsp_csum_ff, rsp_csum_in;

   logic          in_range;
   logic [AW-1:0] blk_addr;
   logic [7:0]    bit_mask;
   logic [7:0]    new_byte;
   logic [15:0]   old_word;
   logic [15:0]   new_word;
   logic [2:0]    zero_pos;
   logic          hit;
   logic          issue;
   logic [BW-1:0] blk_full;

   assign in_range = (32'(blk_ff[10:3]) < 32'(MAP_BYTES));
   assign blk_addr = AW'(blk_ff[10:3]);
   assign bit_mask = 8'(1) << blk_ff[2:0];
   assign old_word = blk_ff[3] ? {rd_data_ff, 8'h00} : {8'h00, rd_data_ff};
   assign new_word = blk_ff[3] ? {new_byte, 8'h00} : {8'h00, new_byte};
   assign hit      = rd_vld_ff && (rd_data_ff != bba_pkg::BYTE_FULL);
   assign issue    = (ptr_ff != CW'(MAP_BYTES));
   assign blk_full = {rd_idx_ff, zero_pos};

   always_comb begin
      zero_pos = 3'd0;
      for (int j = 7; j >= 0; j--) begin
         if (!rd_data_ff[j]) begin
            zero_pos = 3'(j);
         end
      end
   end

   always_comb begin
      unique case (act_ff)
         bba_pkg::ACT_MARK_USED: new_byte = rd_data_ff | bit_mask;
         bba_pkg::ACT_MARK_FREE: new_byte = rd_data_ff & ~bit_mask;
         default:                new_byte = val_ff[7:0];
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      ptr_in       = ptr_ff;
      rd_vld_in    = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = ptr_ff[AW-1:0];
      mem_we       = 1'b0;
      mem_waddr    = clr_ff;
      mem_wdata    = 8'h00;
      act_in       = act_ff;
      blk_in       = blk_ff;
      val_in       = val_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      res_block_in = res_block_ff;
      res_found_in = res_found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_block_in = rsp_block_ff;
      rsp_found_in = rsp_found_ff;
      rsp_count_in = rsp_count_ff;
      rsp_csum_in  = rsp_csum_ff;
      req_ready    = 1'b0;

      unique case (state_ff)
         bba_pkg::ST_CLEAR: begin
            mem_we = 1'b1;
            if (clr_ff == AW'(MAP_BYTES - 1)) begin
               state_in = bba_pkg::ST_IDLE;
            end else begin
               clr_in = clr_ff + AW'(1);
            end
         end
         bba_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            rd_addr   = AW'(req_block[10:3]);
            if (req_valid) begin
               rd_en  = 1'b1;
               act_in = req_action;
               blk_in = req_block;
               val_in = req_value;
               unique case (req_action)
                  bba_pkg::ACT_FIND: begin
                     rd_en    = 1'b0;
                     ptr_in   = '0;
                     state_in = bba_pkg::ST_SCAN;
                  end
                  bba_pkg::ACT_MARK_USED,
                  bba_pkg::ACT_MARK_FREE,
                  bba_pkg::ACT_LOAD: begin
                     state_in = bba_pkg::ST_MODIFY;
                  end
                  bba_pkg::ACT_SET_COUNT: begin
                     count_in     = req_value;
                     res_block_in = 11'd0;
                     res_found_in = 1'b1;
                     state_in     = bba_pkg::ST_RESP;
                  end
                  default: begin
                     res_block_in = 11'd0;
                     res_found_in = 1'b0;
                     state_in     = bba_pkg::ST_RESP;
                  end
               endcase
            end
         end
         bba_pkg::ST_MODIFY: begin
            if (in_range) begin
               mem_we    = 1'b1;
               mem_waddr = blk_addr;
               mem_wdata = new_byte;
               sum_in    = sum_ff + new_word - old_word;
            end
            if (act_ff == bba_pkg::ACT_MARK_USED) begin
               count_in = count_ff + 16'd1;
            end else if (act_ff == bba_pkg::ACT_MARK_FREE) begin
               count_in = count_ff - 16'd1;
            end
            res_block_in = blk_ff;
            res_found_in = 1'b1;
            state_in     = bba_pkg::ST_RESP;
         end
         bba_pkg::ST_SCAN: begin
            if (hit) begin
               res_block_in = 11'(blk_full);
               res_found_in = 1'b1;
               state_in     = bba_pkg::ST_RESP;
            end else if (issue) begin
               rd_en     = 1'b1;
               rd_vld_in = 1'b1;
               ptr_in    = ptr_ff + CW'(1);
            end else if (!rd_vld_ff) begin
               res_block_in = 11'd0;
               res_found_in = 1'b0;
               state_in     = bba_pkg::ST_RESP;
            end
         end
         bba_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_block_in = res_block_ff;
               rsp_found_in = res_found_ff;
               rsp_count_in = count_ff;
               rsp_csum_in  = sum_ff + count_ff + hdr_file_id_ff + hdr_frag_ff;
               state_in     = bba_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bba_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_idx_ff  <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= bba_pkg::ST_CLEAR;
         clr_ff         <= '0;
         ptr_ff         <= '0;
         rd_vld_ff      <= 1'b0;
         count_ff       <= 16'd0;
         sum_ff         <= 16'd0;
         hdr_file_id_ff <= 16'd0;
         hdr_frag_ff    <= 16'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         ptr_ff       <= ptr_in;
         rd_vld_ff    <= rd_vld_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               bba_pkg::CSR_FILE_ID:        hdr_file_id_ff <= csr_wdata;
               bba_pkg::CSR_FRAGMENT_INDEX: hdr_frag_ff    <= csr_wdata;
               default:                     hdr_frag_ff    <= hdr_frag_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      blk_ff       <= blk_in;
      val_ff       <= val_in;
      res_block_ff <= res_block_in;
      res_found_ff <= res_found_in;
      rsp_block_ff <= rsp_block_in;
      rsp_found_ff <= rsp_found_in;
      rsp_count_ff <= rsp_count_in;
      rsp_csum_ff  <= rsp_csum_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found_block   = rsp_block_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_allocated_out = rsp_count_ff;
   assign rsp_checksum      = rsp_csum_ff;

endmodule

// ===== hdl/bba_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_checker
// port-level checks for the block allocation bitmap
// ----------------------------------------------------------------------------
module bba_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [10:0] rsp_found_block,
   input logic        rsp_found,
   input logic [15:0] rsp_allocated_out,
   input logic [15:0] rsp_checksum
);

   // clearing pass follows reset
   assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request taken right after reset");

   // one beat in flight at a time
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second request taken while one is in flight");

   // a miss or undefined action reports block zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_found_block == 11'd0))
      else $error("nonzero block with found low");

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_checksum)
         && $stable(rsp_found_block) && $stable(rsp_allocated_out)))
      else $error("stalled result changed");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (.*);
